// File: rtl/pes_pkg.sv
// Package for the particle Euler step block: types, constants and arithmetic helpers.
package pes_pkg;

	// Default store size.
	localparam int PARTICLES_DEF = 16;

	// Q16.16 fraction bits.
	localparam int QF = 16;

	// Restoring divider: 32-bit magnitude shifted left by the fraction bits.
	localparam int DQW = 32 + QF;
	localparam int DIV_N = DQW;

	// Pipeline stage numbers.
	localparam int ST_FORCE = 6;
	localparam int ST_ACC = ST_FORCE + DIV_N + 1;
	localparam int ST_PROD = ST_ACC + 1;
	localparam int ST_SUM = ST_PROD + 1;
	localparam int ST_LAST = ST_SUM + 1;

	// Configuration register indexes.
	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] REG_MASS = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_GRAVITY = CFG_IW'(1);
	localparam logic [CFG_IW-1:0] REG_DRAG = CFG_IW'(2);
	localparam logic [CFG_IW-1:0] REG_DT = CFG_IW'(3);
	localparam logic [CFG_IW-1:0] REG_WIND = CFG_IW'(4);
	localparam logic [CFG_IW-1:0] REG_WGAIN = CFG_IW'(5);
	localparam logic [CFG_IW-1:0] REG_FLOOR = CFG_IW'(6);

	// Register reset values.
	localparam logic [30:0] MASS_RST = 31'd196608;
	localparam logic [30:0] GRAVITY_RST = 31'd642253;
	localparam logic [30:0] DRAG_RST = 31'd6554;
	localparam logic [30:0] DT_RST = 31'd6554;
	localparam logic [30:0] WIND_RST = 31'd131072;
	localparam logic [30:0] WGAIN_RST = 31'd6554;
	localparam logic signed [31:0] FLOOR_RST = 32'sd0;

	// Item function codes.
	localparam logic FUNC_INIT = 1'b0;
	localparam logic FUNC_STEP = 1'b1;

	// Saturation limits.
	localparam logic signed [31:0] Q_MAX32 = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q_MIN32 = 32'sh8000_0000;

	// State of one particle.
	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
	} state_t;

	// Result of one item.
	typedef struct packed {
		state_t st;
		logic resp;
	} res_t;

	// Item context carried along the pipeline.
	typedef struct packed {
		logic func;
		logic inr;
		logic signed [31:0] svx;
		logic signed [31:0] svy;
		logic signed [31:0] opx;
		logic signed [31:0] opy;
		logic signed [31:0] ovx;
		logic signed [31:0] ovy;
		logic signed [47:0] vxdt;
		logic signed [47:0] vydt;
		logic signed [31:0] dt2;
	} ctx_t;

	// One divider stage: sign, zero flag, partial remainder, dividend/quotient word.
	typedef struct packed {
		logic neg;
		logic zero;
		logic [30:0] rem;
		logic [DQW-1:0] dq;
	} div_t;

	// Signed 32 by 32 product.
	function automatic logic signed [63:0] smul(input logic signed [31:0] a,
		input logic signed [31:0] b);
		smul = a * b;
	endfunction

	// Clamp to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return Q_MAX32;
		end else if (v < -64'sd2147483648) begin
			return Q_MIN32;
		end else begin
			return v[31:0];
		end
	endfunction

	// One restoring division step: shift in a dividend bit, subtract if it fits.
	function automatic div_t div_step(input div_t d, input logic [30:0] m);
		logic [31:0] trial;
		div_t r;
		r = d;
		trial = {d.rem, d.dq[DQW-1]};
		if (trial >= {1'b0, m}) begin
			r.rem = 31'(trial - {1'b0, m});
			r.dq = {d.dq[DQW-2:0], 1'b1};
		end else begin
			r.rem = trial[30:0];
			r.dq = {d.dq[DQW-2:0], 1'b0};
		end
		return r;
	endfunction

	// Apply the sign to the quotient and saturate.
	function automatic logic signed [31:0] div_result(input div_t d);
		if (d.zero) begin
			return 32'sd0;
		end else if (!d.neg) begin
			return (d.dq > 48'h0000_7FFF_FFFF) ? Q_MAX32 : $signed(d.dq[31:0]);
		end else begin
			return (d.dq > 48'h0000_8000_0000) ? Q_MIN32 : -$signed(d.dq[31:0]);
		end
	endfunction

endpackage

// File: rtl/particle_euler_step_top.sv
// Top level of the particle Euler step block: state memory, update pipeline and ports.
// The block holds position and velocity of PARTICLES particles in signed Q16.16 and takes
// one init or step item per cycle unless stalled. Each item reads its particle from the
// state memory, runs through a 58-stage pipeline (multipliers, a 48-stage restoring divider
// for force over mass, then the position and velocity update) and writes the particle back
// as its result enters the output register. Items for different particles follow each
// other every cycle while the output is not held; an item whose particle still has an item
// in the pipeline waits until that item is written back, so repeated updates of one
// particle do not overlap. After reset the memory is cleared one entry per cycle, and no
// item is accepted before the clearing pass ends. Configuration writes are always ready
// and must be issued only while the block is idle.
module particle_euler_step_top
	import pes_pkg::*;
#(
	parameter int PARTICLES = PARTICLES_DEF
) (
	input logic clk,
	input logic arst_n,
	// Input channel
	input logic in_valid,
	output logic in_stall,
	input logic func,
	input logic [3:0] particle,
	input logic signed [31:0] spawn_vel_x,
	input logic signed [31:0] spawn_vel_y,
	// Output channel
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic respawned,
	// Configuration write channel
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IW-1:0] cfg_index,
	input logic [31:0] cfg_data
);

	localparam int AW = (PARTICLES > 1) ? $clog2(PARTICLES) : 1;

	// Configuration registers.
	logic [30:0] mass_q;
	logic [30:0] grav_q;
	logic [30:0] drag_q;
	logic [30:0] dt_q;
	logic [30:0] wind_q;
	logic [30:0] wgain_q;
	logic signed [31:0] floor_q;

	logic signed [31:0] mass_sv;
	logic signed [31:0] grav_sv;
	logic signed [31:0] drag_sv;
	logic signed [31:0] dt_sv;
	logic signed [31:0] wind_sv;
	logic signed [31:0] wgain_sv;

	// Handshake and control.
	logic adv;
	logic hazard;
	logic in_take;
	logic in_inr;
	logic [AW-1:0] in_addr;
	logic clearing_q;
	logic [AW-1:0] clr_q;
	logic out_valid_q;
	res_t out_q;

	// Memory.
	state_t mem [PARTICLES];
	state_t rd_s1;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	state_t wr_data;

	// Pipeline context.
	logic [1:ST_LAST] vld_s;
	ctx_t ctx_s [1:ST_LAST];
	logic [AW-1:0] addr_s [1:ST_LAST];
	ctx_t c1;
	ctx_t c2;
	ctx_t c3;

	// Arithmetic stages.
	logic signed [63:0] p_wy_s2;
	logic signed [63:0] p_vxx_s2;
	logic signed [63:0] p_vyy_s2;
	logic signed [63:0] p_gm_s2;
	logic signed [63:0] p_dt2_s2;
	logic signed [63:0] p_vxdt_s2;
	logic signed [63:0] p_vydt_s2;
	logic signed [31:0] wy_s3;
	logic signed [31:0] vxx_s3;
	logic signed [31:0] vyy_s3;
	logic signed [31:0] gm_s3;
	logic signed [63:0] p_wx_s4;
	logic signed [63:0] p_dx_s4;
	logic signed [63:0] p_dy_s4;
	logic signed [31:0] gm_s4;
	logic signed [31:0] wx_s5;
	logic signed [31:0] dxq_s5;
	logic signed [31:0] dyq_s5;
	logic signed [31:0] gm_s5;
	logic signed [31:0] fx_s6;
	logic signed [31:0] fy_s6;
	div_t dvx_in;
	div_t dvy_in;
	div_t dvx_s [1:DIV_N];
	div_t dvy_s [1:DIV_N];
	logic [31:0] magx;
	logic [31:0] magy;
	logic signed [31:0] ax_s55;
	logic signed [31:0] ay_s55;
	logic signed [63:0] p_ax2_s56;
	logic signed [63:0] p_axdt_s56;
	logic signed [63:0] p_ay2_s56;
	logic signed [63:0] p_aydt_s56;
	state_t sum_s57;
	state_t sum_c;
	res_t res_s58;
	res_t res_c;

	assign mass_sv = $signed({1'b0, mass_q});
	assign grav_sv = $signed({1'b0, grav_q});
	assign drag_sv = $signed({1'b0, drag_q});
	assign dt_sv = $signed({1'b0, dt_q});
	assign wind_sv = $signed({1'b0, wind_q});
	assign wgain_sv = $signed({1'b0, wgain_q});

	// Configuration writes are taken in every cycle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= MASS_RST;
			grav_q <= GRAVITY_RST;
			drag_q <= DRAG_RST;
			dt_q <= DT_RST;
			wind_q <= WIND_RST;
			wgain_q <= WGAIN_RST;
			floor_q <= FLOOR_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MASS: mass_q <= cfg_data[30:0];
				REG_GRAVITY: grav_q <= cfg_data[30:0];
				REG_DRAG: drag_q <= cfg_data[30:0];
				REG_DT: dt_q <= cfg_data[30:0];
				REG_WIND: wind_q <= cfg_data[30:0];
				REG_WGAIN: wgain_q <= cfg_data[30:0];
				REG_FLOOR: floor_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Input decode and the interlock against particles still in the pipeline.
	assign in_addr = AW'(particle);
	assign in_inr = (32'(particle) < 32'(PARTICLES));

	always_comb begin
		hazard = 1'b0;
		for (int i = 1; i <= ST_LAST; i++) begin
			if (vld_s[i] && ctx_s[i].inr && (addr_s[i] == in_addr)) begin
				hazard = 1'b1;
			end
		end
	end

	// The pipeline moves unless a finished beat would run into a held output beat.
	assign adv = !out_valid_q || !out_stall || !vld_s[ST_LAST];
	assign in_stall = clearing_q || !adv || (hazard && in_inr);
	assign in_take = in_valid && !in_stall;

	// Clearing pass after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q <= '0;
		end else if (clearing_q) begin
			if (clr_q == AW'(PARTICLES - 1)) begin
				clearing_q <= 1'b0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Memory write port: clearing pass or write-back of the last stage.
	always_comb begin
		if (clearing_q) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en = adv && vld_s[ST_LAST] && ctx_s[ST_LAST].inr;
			wr_addr = addr_s[ST_LAST];
			wr_data = res_s58.st;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (adv) begin
			rd_s1 <= mem[in_addr];
		end
	end

	// Valid bits of the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s[1] <= in_take;
			for (int i = 2; i <= ST_LAST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Context of each item, completed with the old state and time-step terms.
	always_comb begin
		c1 = '0;
		c1.func = func;
		c1.inr = in_inr;
		c1.svx = spawn_vel_x;
		c1.svy = spawn_vel_y;

		c2 = ctx_s[1];
		c2.opx = rd_s1.px;
		c2.opy = rd_s1.py;
		c2.ovx = rd_s1.vx;
		c2.ovy = rd_s1.vy;

		c3 = ctx_s[2];
		c3.dt2 = sat32(p_dt2_s2 >>> QF);
		c3.vxdt = 48'(p_vxdt_s2 >>> QF);
		c3.vydt = 48'(p_vydt_s2 >>> QF);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s[1] <= c1;
			ctx_s[2] <= c2;
			ctx_s[3] <= c3;
			for (int i = 4; i <= ST_LAST; i++) begin
				ctx_s[i] <= ctx_s[i-1];
			end
			addr_s[1] <= in_addr;
			for (int i = 2; i <= ST_LAST; i++) begin
				addr_s[i] <= addr_s[i-1];
			end
		end
	end

	// Divider inputs: magnitude of the force shifted up by the fraction bits.
	assign magx = fx_s6[31] ? (~fx_s6 + 32'd1) : fx_s6;
	assign magy = fy_s6[31] ? (~fy_s6 + 32'd1) : fy_s6;

	always_comb begin
		dvx_in.neg = fx_s6[31];
		dvx_in.zero = (fx_s6 == 32'sd0);
		dvx_in.rem = '0;
		dvx_in.dq = {magx, {QF{1'b0}}};
		dvy_in.neg = fy_s6[31];
		dvy_in.zero = (fy_s6 == 32'sd0);
		dvy_in.rem = '0;
		dvy_in.dq = {magy, {QF{1'b0}}};
	end

	// Position and velocity sums, one clamp each.
	always_comb begin
		sum_c.px = sat32(64'(ctx_s[ST_PROD].opx) + 64'(ctx_s[ST_PROD].vxdt)
			+ (p_ax2_s56 >>> (QF + 1)));
		sum_c.py = sat32(64'(ctx_s[ST_PROD].opy) + 64'(ctx_s[ST_PROD].vydt)
			+ (p_ay2_s56 >>> (QF + 1)));
		sum_c.vx = sat32(64'(ctx_s[ST_PROD].ovx) + (p_axdt_s56 >>> QF));
		sum_c.vy = sat32(64'(ctx_s[ST_PROD].ovy) + (p_aydt_s56 >>> QF));
	end

	// Final selection: out of range, init, respawn below the floor, or the step.
	always_comb begin
		res_c.st = sum_s57;
		res_c.resp = 1'b0;
		if (!ctx_s[ST_SUM].inr) begin
			res_c = '0;
		end else if ((ctx_s[ST_SUM].func == FUNC_INIT) || (sum_s57.py < floor_q)) begin
			res_c.st.px = '0;
			res_c.st.py = '0;
			res_c.st.vx = ctx_s[ST_SUM].svx;
			res_c.st.vy = ctx_s[ST_SUM].svy;
			res_c.resp = 1'b1;
		end
	end

	// Arithmetic pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			// Products on the old state and the configuration.
			p_wy_s2 <= smul(rd_s1.py, wgain_sv);
			p_vxx_s2 <= smul(rd_s1.vx, rd_s1.vx);
			p_vyy_s2 <= smul(rd_s1.vy, rd_s1.vy);
			p_gm_s2 <= smul(grav_sv, mass_sv);
			p_dt2_s2 <= smul(dt_sv, dt_sv);
			p_vxdt_s2 <= smul(rd_s1.vx, dt_sv);
			p_vydt_s2 <= smul(rd_s1.vy, dt_sv);

			wy_s3 <= sat32(p_wy_s2 >>> QF);
			vxx_s3 <= sat32(p_vxx_s2 >>> QF);
			vyy_s3 <= sat32(p_vyy_s2 >>> QF);
			gm_s3 <= sat32(p_gm_s2 >>> QF);

			// Wind and drag products.
			p_wx_s4 <= smul(wy_s3, wind_sv);
			p_dx_s4 <= smul(drag_sv, vxx_s3);
			p_dy_s4 <= smul(drag_sv, vyy_s3);
			gm_s4 <= gm_s3;

			wx_s5 <= sat32(p_wx_s4 >>> QF);
			dxq_s5 <= sat32(p_dx_s4 >>> QF);
			dyq_s5 <= sat32(p_dy_s4 >>> QF);
			gm_s5 <= gm_s4;

			// Force: drag always opposes the velocity component.
			if (ctx_s[ST_FORCE-1].ovx > 32'sd0) begin
				fx_s6 <= sat32(64'(wx_s5) - 64'(dxq_s5));
			end else begin
				fx_s6 <= sat32(64'(wx_s5) + 64'(dxq_s5));
			end
			if (ctx_s[ST_FORCE-1].ovy > 32'sd0) begin
				fy_s6 <= sat32(-64'(gm_s5) - 64'(dyq_s5));
			end else begin
				fy_s6 <= sat32(-64'(gm_s5) + 64'(dyq_s5));
			end

			// Divider, one quotient bit per stage.
			dvx_s[1] <= div_step(dvx_in, mass_q);
			dvy_s[1] <= div_step(dvy_in, mass_q);
			for (int k = 2; k <= DIV_N; k++) begin
				dvx_s[k] <= div_step(dvx_s[k-1], mass_q);
				dvy_s[k] <= div_step(dvy_s[k-1], mass_q);
			end

			ax_s55 <= div_result(dvx_s[DIV_N]);
			ay_s55 <= div_result(dvy_s[DIV_N]);

			// Acceleration terms.
			p_ax2_s56 <= smul(ax_s55, ctx_s[ST_ACC].dt2);
			p_axdt_s56 <= smul(ax_s55, dt_sv);
			p_ay2_s56 <= smul(ay_s55, ctx_s[ST_ACC].dt2);
			p_aydt_s56 <= smul(ay_s55, dt_sv);

			sum_s57 <= sum_c;
			res_s58 <= res_c;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && vld_s[ST_LAST]) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s[ST_LAST]) begin
			out_q <= res_s58;
		end
	end

	assign out_valid = out_valid_q;
	assign new_pos_x = out_q.st.px;
	assign new_pos_y = out_q.st.py;
	assign new_vel_x = out_q.st.vx;
	assign new_vel_y = out_q.st.vy;
	assign respawned = out_q.resp;

endmodule
